### rtl/core/wdh_pkg.sv
package wdh_pkg;

    // Item kinds on the command port
    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_READ_BIN  = 2'd1,
        KIND_READ_FILL = 2'd2,
        KIND_CLEAR     = 2'd3
    } kind_t;

    // Sample classification reported with each result
    typedef enum logic [1:0] {
        CLASS_BIN  = 2'd0,
        CLASS_FILL = 2'd1,
        CLASS_OUT  = 2'd2
    } class_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RANGE_LOW  = 2'd0,
        CFG_RANGE_HIGH = 2'd1,
        CFG_FILL_VALUE = 2'd2,
        CFG_LAYERS     = 2'd3
    } cfg_index_t;

    // Operation carried into the update stage
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_INC_BIN  = 3'd1,
        OP_INC_FILL = 3'd2,
        OP_RD_BIN   = 3'd3,
        OP_RD_FILL  = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    // Controller states
    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

    localparam int          CNT_W   = 32;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    localparam logic [31:0] RANGE_LOW_RST  = 32'sd0;
    localparam logic [31:0] RANGE_HIGH_RST = 32'sd255;
    localparam logic [31:0] FILL_VALUE_RST = 32'sd0;
    localparam logic [2:0]  LAYERS_RST     = 3'd1;

endpackage

### rtl/core/windowed_histogram_with_fill_count.sv
// An accepted item passes the update stage registers and then the result registers before
// its done strobe; one item per cycle sustained while busy is low, set by the single
// read-modify-write pass over the bin memory (forwarded back to back). A clear item answers
// like any other item and holds busy while the memory is swept to zero, one entry per cycle.
// Reset: asynchronous, active low; after reset the same sweep runs with busy high.
// The receiver cannot stall: each done strobe lasts exactly one cycle.
module windowed_histogram_with_fill_count
    import wdh_pkg::*;
#(
    parameter int NUM_BINS   = 4096,
    parameter int NUM_LAYERS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command port
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic signed [31:0] sample_value,
    input  logic [1:0]         layer,
    input  logic [11:0]        bin_index,
    // configuration port
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    // result port
    output logic               done,
    output logic [31:0]        count,
    output logic [1:0]         sample_class
);

    localparam int DEPTH   = NUM_LAYERS * NUM_BINS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    // holds the 3-bit layer register as well as NUM_LAYERS
    localparam int LCNT_W  = (($clog2(NUM_LAYERS + 1) > 3) ? $clog2(NUM_LAYERS + 1) : 3) + 1;

    // configuration registers
    logic signed [31:0] range_low_reg;
    logic signed [31:0] range_high_reg;
    logic signed [31:0] fill_value_reg;
    logic [2:0]         layers_reg;

    // controller
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               accept;

    // decode stage signals
    kind_t              kind_in;
    logic [LCNT_W-1:0]  layers_eff;
    logic               layer_ok;
    logic [LAYER_W+1:0] layer_ext;
    logic [LAYER_W-1:0] layer_idx;
    logic signed [32:0] diff;
    logic               in_window;
    logic               bin_ok;
    logic [16:0]        bin_ext;
    logic [BIN_W-1:0]   bin_sel;
    logic [ADDR_W-1:0]  addr_s0;
    op_t                op_s0;
    class_t             class_s0;

    // update stage registers
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    class_t             s1_class_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [LAYER_W-1:0] s1_layer_reg;

    // memory, forwarding and counters
    logic [CNT_W-1:0]   mem [DEPTH];
    logic [CNT_W-1:0]   rd_data_reg;
    logic               wb_valid_reg;
    logic [ADDR_W-1:0]  wb_addr_reg;
    logic [CNT_W-1:0]   wb_data_reg;
    logic [CNT_W-1:0]   fill_reg [NUM_LAYERS];
    logic [CNT_W-1:0]   bin_cur;
    logic [CNT_W-1:0]   fill_cur;
    logic [CNT_W-1:0]   inc_src;
    logic [CNT_W-1:0]   inc_val;
    logic [CNT_W-1:0]   count_next;
    logic               bin_we;

    // result registers
    logic               done_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         class_reg;

    assign accept  = start && !busy;
    assign kind_in = kind_t'(kind);

    // controller state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // next state: sweep the memory after reset and after a clear item
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        busy          = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                busy          = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next    = ST_RUN;
                    clr_addr_next = '0;
                end
            end
            ST_RUN:
            begin
                if (accept && kind_in == KIND_CLEAR)
                begin
                    state_next    = ST_CLEAR;
                    clr_addr_next = '0;
                end
            end
            default:
            begin
                state_next    = ST_CLEAR;
                clr_addr_next = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RST;
            range_high_reg <= RANGE_HIGH_RST;
            fill_value_reg <= FILL_VALUE_RST;
            layers_reg     <= LAYERS_RST;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_RANGE_LOW:  range_low_reg  <= wr_data;
                CFG_RANGE_HIGH: range_high_reg <= wr_data;
                CFG_FILL_VALUE: fill_value_reg <= wr_data;
                CFG_LAYERS:     layers_reg     <= wr_data[2:0];
                default: ;
            endcase
        end
    end

    // effective layer count, clamped to 1..NUM_LAYERS
    always_comb
    begin
        layers_eff = (layers_reg == 3'd0) ? LCNT_W'(1) : LCNT_W'(layers_reg);
        if (layers_eff > LCNT_W'(NUM_LAYERS))
            layers_eff = LCNT_W'(NUM_LAYERS);
    end

    assign layer_ok  = LCNT_W'(layer) < layers_eff;
    assign layer_ext = (LAYER_W + 2)'(layer);
    assign layer_idx = layer_ext[LAYER_W-1:0];

    // window check: offset from range_low in 33 bits cannot overflow
    assign diff      = {sample_value[31], sample_value} - {range_low_reg[31], range_low_reg};
    assign in_window = !diff[32] && (sample_value <= range_high_reg)
                       && (diff < 33'(NUM_BINS));

    assign bin_ext = 17'(bin_index);
    assign bin_ok  = bin_ext < 17'(NUM_BINS);

    // decode the item into an operation and a memory address
    always_comb
    begin
        op_s0    = OP_NONE;
        class_s0 = CLASS_BIN;
        bin_sel  = bin_ext[BIN_W-1:0];
        case (kind_in)
            KIND_SAMPLE:
            begin
                class_s0 = CLASS_OUT;
                bin_sel  = diff[BIN_W-1:0];
                if (layer_ok)
                begin
                    if (sample_value == fill_value_reg)
                    begin
                        op_s0    = OP_INC_FILL;
                        class_s0 = CLASS_FILL;
                    end
                    else if (in_window)
                    begin
                        op_s0    = OP_INC_BIN;
                        class_s0 = CLASS_BIN;
                    end
                end
            end
            KIND_READ_BIN:
            begin
                if (layer_ok && bin_ok)
                    op_s0 = OP_RD_BIN;
            end
            KIND_READ_FILL:
            begin
                if (layer_ok)
                    op_s0 = OP_RD_FILL;
            end
            KIND_CLEAR:
            begin
                op_s0 = OP_CLEAR;
            end
            default:
            begin
                op_s0 = OP_NONE;
            end
        endcase
    end

    assign addr_s0 = ADDR_W'(layer_idx) * ADDR_W'(NUM_BINS) + ADDR_W'(bin_sel);

    // update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            wb_valid_reg <= bin_we;
            done_reg     <= s1_valid_reg;
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= op_s0;
            s1_class_reg <= class_s0;
            s1_addr_reg  <= addr_s0;
            s1_layer_reg <= layer_idx;
        end
        if (bin_we)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= inc_val;
        end
        if (s1_valid_reg)
        begin
            count_reg <= count_next;
            class_reg <= s1_class_reg;
        end
    end

    // bin memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            mem[clr_addr_reg] <= '0;
        else if (bin_we)
            mem[s1_addr_reg] <= inc_val;
        rd_data_reg <= mem[addr_s0];
    end

    // forward the previous write, which the memory read did not yet see
    assign bin_cur  = (wb_valid_reg && wb_addr_reg == s1_addr_reg) ? wb_data_reg : rd_data_reg;
    assign fill_cur = fill_reg[s1_layer_reg];
    assign inc_src  = (s1_op_reg == OP_INC_FILL) ? fill_cur : bin_cur;
    assign inc_val  = (inc_src == CNT_MAX) ? inc_src : inc_src + 1'b1;
    assign bin_we   = s1_valid_reg && (s1_op_reg == OP_INC_BIN);

    // result value per operation
    always_comb
    begin
        case (s1_op_reg)
            OP_INC_BIN:  count_next = inc_val;
            OP_INC_FILL: count_next = inc_val;
            OP_RD_BIN:   count_next = bin_cur;
            OP_RD_FILL:  count_next = fill_cur;
            OP_CLEAR:    count_next = '0;
            OP_NONE:     count_next = '0;
            default:     count_next = '0;
        endcase
    end

    // fill counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LAYERS; i++)
                fill_reg[i] <= '0;
        end
        else if (s1_valid_reg && s1_op_reg == OP_CLEAR)
        begin
            for (int i = 0; i < NUM_LAYERS; i++)
                fill_reg[i] <= '0;
        end
        else if (s1_valid_reg && s1_op_reg == OP_INC_FILL)
        begin
            fill_reg[s1_layer_reg] <= inc_val;
        end
    end

    assign done         = done_reg;
    assign count        = count_reg;
    assign sample_class = class_reg;

endmodule

### tb/tb_windowed_histogram_with_fill_count.sv
`timescale 1ns / 1ps

import wdh_pkg::*;

// Tracks the histogram contents and register settings, predicts the answer to each
// accepted command and checks the answers that come back in order.
class histogram_tracker;
    localparam int NBINS   = 4096;
    localparam int NLAYERS = 4;

    typedef struct {
        logic [31:0] count;
        class_t      cls;
    } answer_t;

    longint      win_lo;
    longint      win_hi;
    longint      fill_mark;
    logic [2:0]  layer_cfg;
    logic [31:0] bin_tally [NBINS*NLAYERS];
    logic [31:0] fill_tally [NLAYERS];
    answer_t     pending [$];
    int          mismatches;
    int          checked;
    int          n_binned;
    int          n_fill;
    int          n_out;
    int          n_clear;

    function new();
        win_lo     = 0;
        win_hi     = 255;
        fill_mark  = 0;
        layer_cfg  = 3'd1;
        mismatches = 0;
        checked    = 0;
        n_binned   = 0;
        n_fill     = 0;
        n_out      = 0;
        n_clear    = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        foreach (fill_tally[i])
            fill_tally[i] = '0;
    endfunction

    // saturating counter step
    function logic [31:0] bump(logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function void set_register(cfg_index_t idx, logic [31:0] data);
        case (idx)
            CFG_RANGE_LOW:  win_lo    = longint'($signed(data));
            CFG_RANGE_HIGH: win_hi    = longint'($signed(data));
            CFG_FILL_VALUE: fill_mark = longint'($signed(data));
            default:        layer_cfg = data[2:0];
        endcase
    endfunction

    // Apply one accepted command and queue the answer it must produce
    function void note_command(kind_t k, logic [31:0] v, logic [1:0] ly, logic [11:0] bi);
        longint      sv;
        int unsigned live;
        int unsigned slot;
        answer_t     a;
        sv   = longint'($signed(v));
        live = (layer_cfg == 3'd0) ? 1 : (layer_cfg > NLAYERS) ? NLAYERS : layer_cfg;
        a.count = '0;
        a.cls   = CLASS_BIN;
        case (k)
            KIND_SAMPLE: begin
                a.cls = CLASS_OUT;
                if (ly < live) begin
                    // fill match wins over the window
                    if (sv == fill_mark) begin
                        fill_tally[ly] = bump(fill_tally[ly]);
                        a.count = fill_tally[ly];
                        a.cls   = CLASS_FILL;
                    end
                    else if (sv >= win_lo && sv <= win_hi && sv - win_lo < NBINS) begin
                        slot = ly * NBINS + int'(sv - win_lo);
                        bin_tally[slot] = bump(bin_tally[slot]);
                        a.count = bin_tally[slot];
                        a.cls   = CLASS_BIN;
                    end
                end
                case (a.cls)
                    CLASS_BIN:  n_binned++;
                    CLASS_FILL: n_fill++;
                    default:    n_out++;
                endcase
            end
            KIND_READ_BIN: begin
                if (ly < live && bi < NBINS)
                    a.count = bin_tally[ly * NBINS + bi];
            end
            KIND_READ_FILL: begin
                if (ly < live)
                    a.count = fill_tally[ly];
            end
            default: begin
                wipe();
                n_clear++;
            end
        endcase
        pending.push_back(a);
    endfunction

    function void check_answer(logic [31:0] c, logic [1:0] cl);
        answer_t a;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with none pending: count=%h class=%0d", $time, c, cl);
            return;
        end
        a = pending.pop_front();
        checked++;
        if (c !== a.count || cl !== a.cls) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch: expected count=%h class=%0d, got count=%h class=%0d",
                         $time, a.count, a.cls, c, cl);
        end
    endfunction
endclass

module tb_windowed_histogram_with_fill_count;

    localparam int     STALL_LIMIT = 60000;
    localparam int     N_PHASES    = 10;
    localparam int     PHASE_ITEMS = 168;
    localparam longint S32_MIN     = -64'sd2147483648;
    localparam longint S32_MAX     = 64'sd2147483647;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    kind_t              kind;
    logic signed [31:0] sample_value;
    logic [1:0]         layer;
    logic [11:0]        bin_index;
    logic               wr_en;
    cfg_index_t         wr_index;
    logic [31:0]        wr_data;
    logic               done;
    logic [31:0]        count;
    logic [1:0]         sample_class;

    histogram_tracker sb;
    int               n_sent;
    int               n_settings;
    int               stall_cycles;

    windowed_histogram_with_fill_count dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .sample_value (sample_value),
        .layer        (layer),
        .bin_index    (bin_index),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .count        (count),
        .sample_class (sample_class)
    );

    always #5 clk = ~clk;

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_answer(count, sample_class);
    end

    // watchdog: cycles without any transfer, write or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done || wr_en)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no activity for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One command transfer, optionally preceded by an idle gap
    task automatic send_command(kind_t k, logic [31:0] v, logic [1:0] ly, logic [11:0] bi,
                                int gap);
        if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        kind         <= k;
        sample_value <= v;
        layer        <= ly;
        bin_index    <= bi;
        do @(posedge clk); while (busy);
        sb.note_command(k, v, ly, bi);
        n_sent++;
    endtask

    // Drain all answers and any clear sweep before touching registers
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        sb.set_register(idx, data);
    endtask

    task automatic program_window(longint lo, longint hi, longint fv, logic [2:0] nl);
        settle();
        write_reg(CFG_RANGE_LOW, lo[31:0]);
        write_reg(CFG_RANGE_HIGH, hi[31:0]);
        write_reg(CFG_FILL_VALUE, fv[31:0]);
        write_reg(CFG_LAYERS, {29'd0, nl});
        @(negedge clk);
        wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic random_window();
        longint lo;
        longint hi;
        longint fv;
        if ($urandom_range(0, 1))
            lo = longint'($signed($urandom()));
        else
            lo = longint'($urandom_range(0, 6000)) - 3000;
        hi = lo + longint'($urandom_range(0, 5000));
        // sometimes an empty window
        if ($urandom_range(0, 5) == 0)
            hi = lo - longint'($urandom_range(1, 100));
        if (hi > S32_MAX)
            hi = S32_MAX;
        if (hi < S32_MIN)
            hi = S32_MIN;
        if ($urandom_range(0, 1))
            fv = lo + longint'($urandom_range(0, 300));
        else
            fv = longint'($signed($urandom()));
        program_window(lo, hi, fv, 3'($urandom_range(0, 7)));
    endtask

    // Sample value biased toward the window, the fill marker and the edges
    function automatic logic [31:0] pick_value();
        longint      top;
        longint      v;
        int unsigned r;
        r   = $urandom_range(0, 99);
        top = sb.win_hi;
        if (top > sb.win_lo + 4095)
            top = sb.win_lo + 4095;
        if (r < 55 && top >= sb.win_lo) begin
            if (r < 30 && top - sb.win_lo > 15)
                v = sb.win_lo + longint'($urandom_range(0, 15));
            else
                v = sb.win_lo + longint'($urandom_range(0, int'(top - sb.win_lo)));
        end
        else if (r < 70) begin
            v = sb.fill_mark;
        end
        else if (r < 85) begin
            case ($urandom_range(0, 7))
                0:       v = sb.win_lo - 1;
                1:       v = sb.win_lo;
                2:       v = sb.win_hi;
                3:       v = sb.win_hi + 1;
                4:       v = sb.win_lo + 4095;
                5:       v = sb.win_lo + 4096;
                6:       v = sb.fill_mark - 1;
                default: v = sb.fill_mark + 1;
            endcase
        end
        else begin
            v = longint'($signed($urandom()));
        end
        return v[31:0];
    endfunction

    task automatic run_random(int n, bit allow_idle);
        int unsigned r;
        int          gap;
        kind_t       k;
        logic [11:0] bi;
        repeat (n) begin
            r   = $urandom_range(0, 199);
            gap = 0;
            if (allow_idle && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 9);
            if (r == 0)
                k = KIND_CLEAR;
            else if (r < 120)
                k = KIND_SAMPLE;
            else if (r < 165)
                k = KIND_READ_BIN;
            else
                k = KIND_READ_FILL;
            // reads land on the hot bins half of the time
            if ($urandom_range(0, 1))
                bi = 12'($urandom_range(0, 15));
            else
                bi = 12'($urandom());
            send_command(k, pick_value(), 2'($urandom_range(0, 3)), bi, gap);
        end
    endtask

    initial
    begin
        sb           = new();
        n_sent       = 0;
        n_settings   = 0;
        stall_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_SAMPLE;
        sample_value = '0;
        layer        = '0;
        bin_index    = '0;
        wr_en        = 1'b0;
        wr_index     = CFG_RANGE_LOW;
        wr_data      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, back to back, with reset settings: window 0..255, fill 0, one layer
        send_command(KIND_SAMPLE, 32'd0, 2'd0, 12'd0, 0);          // fill inside window
        send_command(KIND_SAMPLE, 32'd1, 2'd0, 12'd0, 0);
        send_command(KIND_SAMPLE, 32'd255, 2'd0, 12'd0, 0);        // top of window
        send_command(KIND_SAMPLE, 32'd256, 2'd0, 12'd0, 0);        // just above
        send_command(KIND_SAMPLE, 32'hFFFF_FFFF, 2'd0, 12'd0, 0);  // just below
        send_command(KIND_SAMPLE, 32'h7FFF_FFFF, 2'd0, 12'd0, 0);
        send_command(KIND_SAMPLE, 32'h8000_0000, 2'd0, 12'd0, 0);
        send_command(KIND_SAMPLE, 32'd5, 2'd1, 12'd0, 0);          // layer not in use
        send_command(KIND_SAMPLE, 32'd0, 2'd3, 12'd0, 0);          // fill on unused layer
        send_command(KIND_SAMPLE, 32'd1, 2'd0, 12'd0, 0);
        send_command(KIND_READ_BIN, 32'd0, 2'd0, 12'd1, 0);
        send_command(KIND_READ_BIN, 32'd0, 2'd0, 12'hFFF, 0);
        send_command(KIND_READ_BIN, 32'd0, 2'd2, 12'd1, 0);
        send_command(KIND_READ_FILL, 32'd0, 2'd0, 12'd0, 0);
        send_command(KIND_READ_FILL, 32'd0, 2'd3, 12'd0, 0);
        send_command(KIND_CLEAR, 32'd0, 2'd0, 12'd0, 0);
        send_command(KIND_READ_BIN, 32'd0, 2'd0, 12'd1, 0);
        send_command(KIND_READ_FILL, 32'd0, 2'd0, 12'd0, 0);
        send_command(KIND_SAMPLE, 32'd255, 2'd0, 12'd0, 0);
        // same bin back to back exercises forwarding
        send_command(KIND_SAMPLE, 32'd7, 2'd0, 12'd0, 0);
        send_command(KIND_SAMPLE, 32'd7, 2'd0, 12'd0, 0);
        send_command(KIND_SAMPLE, 32'd7, 2'd0, 12'd0, 0);
        send_command(KIND_READ_BIN, 32'd0, 2'd0, 12'd7, 0);

        // random phases over a spread of register settings
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: program_window(-100, 100, 7, 3'd4);
                1: program_window(S32_MIN, S32_MAX, S32_MAX, 3'd7);
                2: program_window(S32_MAX - 255, S32_MAX, S32_MIN, 3'd0);
                3: program_window(50, 10, -1, 3'd2);
                4: program_window(-2048, 2047, -2048, 3'd3);
                5: program_window(1000, 5095, 999, 3'd5);
                default: random_window();
            endcase
            run_random(PHASE_ITEMS, p != N_PHASES - 1);
        end

        // drain and wrap up
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d commands under %0d register settings, %0d clears",
                 n_sent, n_settings + 1, sb.n_clear);
        $display("Samples: %0d binned, %0d fill, %0d out of range; %0d answers checked, %0d bad",
                 sb.n_binned, sb.n_fill, sb.n_out, sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
